/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, switched off while reset is asserted.
`define KDE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Property checked at every rising edge, reset included.
`define KDE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

/* rtl/core/kde_pkg.sv */
`default_nettype none

package kde_pkg;

    localparam int FEAT_W     = 16;
    localparam int GAP_W      = 17;
    localparam int SQ_W       = 2 * GAP_W;
    localparam int SUM_W      = 42;
    localparam int DIST_W     = 21;
    localparam int LABEL_W    = 8;
    localparam int REM_W      = DIST_W + 2;
    localparam int ROOT_STEPS = SUM_W / 2;
    localparam int ADDR_W     = 3;

    // Metric register codes
    localparam logic METRIC_EUCLID = 1'b0;
    localparam logic METRIC_CHEBY  = 1'b1;

    // Register index as seen in paddr[2]
    localparam logic REG_METRIC = 1'b0;

    typedef struct packed {
        logic signed [FEAT_W-1:0] test_value;
        logic signed [FEAT_W-1:0] train_value;
        logic [LABEL_W-1:0]       train_label;
        logic                     last;
    } kde_feature_t;

    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [LABEL_W-1:0] label;
    } kde_result_t;

    typedef struct packed {
        logic [SUM_W-1:0]   square_sum;
        logic [GAP_W-1:0]   largest_gap;
        logic [LABEL_W-1:0] label;
        logic               metric;
    } kde_row_t;

    typedef struct packed {
        logic full;
        logic empty;
    } kde_qstat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROOT,
        BK_EMIT
    } kde_back_state_t;

endpackage

`default_nettype wire

/* rtl/core/kde_front.sv */
`default_nettype none

module kde_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                feature_valid,
    output logic                     feature_stall,
    input  wire kde_pkg::kde_feature_t feature,
    input  wire logic                metric,
    input  wire kde_pkg::kde_qstat_t qstat,
    output logic                     push,
    output kde_pkg::kde_row_t        push_row
);
    import kde_pkg::*;

    logic               advance;
    logic [GAP_W-1:0]   diff;
    logic [GAP_W-1:0]   gap;

    logic               s1_valid_reg;
    logic [GAP_W-1:0]   s1_gap_reg;
    logic               s1_last_reg;
    logic [LABEL_W-1:0] s1_label_reg;

    logic               s2_valid_reg;
    logic [SQ_W-1:0]    s2_sq_reg;
    logic [GAP_W-1:0]   s2_gap_reg;
    logic               s2_last_reg;
    logic [LABEL_W-1:0] s2_label_reg;

    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [GAP_W-1:0]   max_reg;
    logic [GAP_W-1:0]   max_next;
    logic [SUM_W:0]     sum_wide;

    // The whole pipeline holds while a finished row cannot enter the queue.
    assign advance       = !(s2_valid_reg && s2_last_reg && qstat.full);
    assign feature_stall = !advance;

    assign diff = {feature.test_value[FEAT_W-1], feature.test_value}
                - {feature.train_value[FEAT_W-1], feature.train_value};
    assign gap  = diff[GAP_W-1] ? (~diff + GAP_W'(1)) : diff;

    always_comb
    begin
        sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(s2_sq_reg);
        sum_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
        max_next = (s2_gap_reg > max_reg) ? s2_gap_reg : max_reg;
        push     = advance && s2_valid_reg && s2_last_reg;
        push_row.square_sum  = sum_next;
        push_row.largest_gap = max_next;
        push_row.label       = s2_label_reg;
        push_row.metric      = metric;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            sum_reg      <= '0;
            max_reg      <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg <= feature_valid;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg)
            begin
                if (s2_last_reg)
                begin
                    sum_reg <= '0;
                    max_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_next;
                    max_reg <= max_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_gap_reg   <= gap;
            s1_last_reg  <= feature.last;
            s1_label_reg <= feature.train_label;
            s2_sq_reg    <= s1_gap_reg * s1_gap_reg;
            s2_gap_reg   <= s1_gap_reg;
            s2_last_reg  <= s1_last_reg;
            s2_label_reg <= s1_label_reg;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/kde_queue.sv */
`default_nettype none

module kde_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire kde_pkg::kde_row_t push_row,
    input  wire logic              pop,
    output kde_pkg::kde_row_t      pop_row,
    output kde_pkg::kde_qstat_t    qstat
);
    import kde_pkg::*;

    kde_row_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign pop_row     = entry_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_row;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/kde_back.sv */
`default_nettype none

module kde_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire kde_pkg::kde_qstat_t qstat,
    input  wire kde_pkg::kde_row_t   pop_row,
    output logic                     pop,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output kde_pkg::kde_result_t     result
);
    import kde_pkg::*;

    localparam int STEP_W = $clog2(ROOT_STEPS);

    kde_back_state_t    state_reg;
    kde_back_state_t    state_next;

    logic [SUM_W-1:0]   rad_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [DIST_W-1:0]  root_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [LABEL_W-1:0] label_reg;
    logic               result_valid_reg;
    kde_result_t        result_reg;

    logic               out_free;
    logic               load;
    logic               last_step;
    logic [REM_W+1:0]   rem_sh;
    logic [REM_W+1:0]   trial;
    logic [REM_W+1:0]   rem_diff;

    assign out_free     = !result_valid_reg || !result_stall;
    assign last_step    = (step_reg == STEP_W'(ROOT_STEPS - 1));
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // One result bit per step: restoring digit-by-digit square root.
    assign rem_sh   = {rem_reg, rad_reg[SUM_W-1 -: 2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign rem_diff = rem_sh - trial;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = (pop_row.metric == METRIC_CHEBY) ? BK_EMIT : BK_ROOT;
                end
            end
            BK_ROOT:
            begin
                if (last_step)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop  = 1'b0;
        load = 1'b0;
        unique case (state_reg)
            BK_IDLE: pop  = !qstat.empty;
            BK_ROOT: ;
            BK_EMIT: load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rad_reg   <= pop_row.square_sum;
            rem_reg   <= '0;
            step_reg  <= '0;
            label_reg <= pop_row.label;
            root_reg  <= (pop_row.metric == METRIC_CHEBY) ?
                         DIST_W'(pop_row.largest_gap) : '0;
        end
        else if (state_reg == BK_ROOT)
        begin
            rad_reg  <= {rad_reg[SUM_W-3:0], 2'b00};
            step_reg <= step_reg + STEP_W'(1);
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_diff[REM_W-1:0];
                root_reg <= {root_reg[DIST_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[REM_W-1:0];
                root_reg <= {root_reg[DIST_W-2:0], 1'b0};
            end
        end
        if (load)
        begin
            result_reg.distance <= root_reg;
            result_reg.label    <= label_reg;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/knn_distance_engine.sv */
`default_nettype none
// Distance engine for k-nearest-neighbour search.
// The feature channel (feature_valid, feature_stall, feature) takes one pair of
// matching test and training features per transfer, signed Q8.8; the transfer
// with feature.last set closes the row and carries the training class label.
// For each closed row the result channel (result_valid, result_stall, result)
// gives one transfer: the Euclidean distance (square root of the sum of squared
// differences, rounded down) or the Chebyshev distance (largest absolute
// difference), chosen by the metric register on the APB port, with the label.
// The front takes one feature per cycle while it does not stall. A Chebyshev
// row passes through the front stage registers, the queue and the idle and emit
// states into the result register; a Euclidean row also passes through the
// root state, as the root unit resolves one result bit per cycle. The back end
// takes a new row only once it has handed on the last; a two-row queue sits
// between, so the front stalls only when a finished row meets a full queue.
// Reset clears both accumulators, the queue and the result valid flag, and sets
// the metric to Euclidean. While the receiver stalls, the result holds and the
// front keeps accepting features until the queue fills.

module knn_distance_engine (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    feature_valid,
    output logic                         feature_stall,
    input  wire kde_pkg::kde_feature_t   feature,
    output logic                         result_valid,
    input  wire logic                    result_stall,
    output kde_pkg::kde_result_t         result,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [2:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import kde_pkg::*;

    logic       metric_reg;
    logic       push;
    logic       pop;
    kde_row_t   push_row;
    kde_row_t   pop_row;
    kde_qstat_t qstat;

    // The port never waits, so every access completes in its access cycle.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg <= METRIC_EUCLID;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_METRIC))
        begin
            metric_reg <= pwdata[0];
        end
    end

    // Only the metric register exists, decoded from paddr[2] alone; an address with paddr[2] set reads as zero.
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_METRIC)
        begin
            prdata = {31'd0, metric_reg};
        end
    end

    // The front end differences, squares and accumulates each feature pair, tracks
    // the largest gap, and hands a finished row to the queue.
    kde_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .feature_valid (feature_valid),
        .feature_stall (feature_stall),
        .feature       (feature),
        .metric        (metric_reg),
        .qstat         (qstat),
        .push          (push),
        .push_row      (push_row)
    );

    kde_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_row (push_row),
        .pop      (pop),
        .pop_row  (pop_row),
        .qstat    (qstat)
    );

    // The back end takes the root of each Euclidean row and drives the
    // output register.
    kde_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (qstat),
        .pop_row      (pop_row),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

/* rtl/core/kde_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module kde_checker (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  feature_valid,
    input  wire logic                  feature_stall,
    input  wire kde_pkg::kde_feature_t feature,
    input  wire logic                  result_valid,
    input  wire logic                  result_stall,
    input  wire kde_pkg::kde_result_t  result,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    input  wire logic [31:0]           prdata,
    input  wire logic                  pready
);

    // No result is offered while reset is asserted.
    `KDE_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> !result_valid, "result valid in reset")

    // A stalled result stays offered and unchanged.
    `KDE_ASSERT(a_result_hold, clk, rst_n,
        result_valid && result_stall |=> result_valid && $stable(result),
        "stalled result changed")

    // A stalled feature stays offered and unchanged.
    `KDE_ASSERT(a_feature_hold, clk, rst_n,
        feature_valid && feature_stall |=> feature_valid && $stable(feature),
        "stalled feature changed")

    // A metric write is seen by a read in the following cycle.
    `KDE_ASSERT(a_metric_readback, clk, rst_n,
        (psel && penable && pwrite && pready && !paddr[2]) ##1 (psel && !pwrite && !paddr[2])
            |-> prdata[0] == $past(pwdata[0]),
        "metric readback mismatch")

endmodule

bind knn_distance_engine kde_checker u_kde_checker (.*);

`default_nettype wire
